// ----- hdl/gpio_port_with_lock_macros.svh -----
// Assertion macros used by the GPIO port register file.
`ifndef GPIO_PORT_WITH_LOCK_MACROS_SVH
`define GPIO_PORT_WITH_LOCK_MACROS_SVH

// Same-cycle implication, clocked on clk, held off during reset.
`define GPL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, held off during reset.
`define GPL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/gpl_pkg.sv -----
// Types, codes and helpers for the GPIO port with configuration lock.
package gpl_pkg;

	localparam int unsigned NUM_PINS     = 16;
	localparam int unsigned WORD_W       = 32;
	localparam int unsigned LOCK_KEY_BIT = 16;
	localparam logic [WORD_W-1:0] CFG_RESET = 32'h4444_4444;
	localparam logic [3:0] NIBBLE = 4'hf;

	typedef enum logic {
		FUNC_READ  = 1'b0,
		FUNC_WRITE = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		REG_CFG_LO = 3'd0,
		REG_CFG_HI = 3'd1,
		REG_IN     = 3'd2,
		REG_OUT    = 3'd3,
		REG_SET    = 3'd4,
		REG_RESET  = 3'd5,
		REG_LOCK   = 3'd6
	} sel_t;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_W1     = 6'b000010,
		ST_W2     = 6'b000100,
		ST_W3     = 6'b001000,
		ST_R1     = 6'b010000,
		ST_LOCKED = 6'b100000
	} lock_step_t;

	typedef struct packed {
		func_t                 func;
		sel_t                  sel;
		logic [WORD_W-1:0]     wdata;
		logic [NUM_PINS-1:0]   pins;
	} access_t;

	typedef struct packed {
		logic [WORD_W-1:0]     rdata;
		logic [NUM_PINS-1:0]   pins_driven;
		logic                  lock_active;
	} result_t;

	// Expand eight pin bits into the matching configuration nibbles.
	function automatic logic [WORD_W-1:0] nibble_mask(input logic [7:0] pins8);
		logic [WORD_W-1:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (pins8[i]) begin
				m[4*i +: 4] = NIBBLE;
			end
		end
		return m;
	endfunction

endpackage

// ----- hdl/gpio_port_with_lock.sv -----
// Top level of the 16-pin GPIO port with configuration lock.
// Each input transaction is one bus access (read or write of one register) and gives exactly
// one result transaction. The port takes one transaction per clock cycle for as long as the
// result side keeps up. An accepted access is held in the input register until its result
// is loaded into the result register and presented on the master side from there;
// the register update itself is a single pass of combinational logic between the input
// register and the result register. While the result side stalls, the port holds two
// transactions, one in each register, and then drops s_tready until the result is taken.
// Both configuration words reset to 0x44444444. After the lock key sequence (write bit 16
// high, low, high with an unchanged pin mask, then two reads of the lock register) the
// configuration nibbles of the masked pins and the lock register stay frozen until reset;
// the output data, set and reset registers are never locked.
module gpio_port_with_lock (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // write_data[31:0], pin_levels[47:32]
	input  logic [3:0]  s_tuser,  // func[0], reg_select[3:1]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata   // read_data[31:0], pins_driven[47:32], lock_active[48]
);
	import gpl_pkg::*;

	logic    valid_s1;
	access_t acc_s1;
	logic    out_valid_q;
	result_t res_q;
	result_t res;
	logic    advance;
	logic    en;
	logic    s_take;

	// Let the stage move on whenever the result register is empty or being drained.
	assign advance  = !out_valid_q || m_tready;
	assign en       = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign s_take   = s_tvalid && s_tready;

	// Input register: hold the accepted transaction until it reaches the result side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_take) begin
			valid_s1 <= 1'b1;
		end else if (en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_take) begin
			acc_s1.func  <= func_t'(s_tuser[0]);
			acc_s1.sel   <= sel_t'(s_tuser[3:1]);
			acc_s1.wdata <= s_tdata[31:0];
			acc_s1.pins  <= s_tdata[47:32];
		end
	end

	// Register file: update the port state and form the result in one pass.
	gpl_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.acc    (acc_s1),
		.res    (res)
	);

	// Result register: load on advance, drop the valid once the transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, res_q.lock_active, res_q.pins_driven, res_q.rdata};

endmodule

// ----- hdl/gpl_regs.sv -----
// Register file and lock key sequencer of the GPIO port.
`include "gpio_port_with_lock_macros.svh"

module gpl_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  gpl_pkg::access_t acc,
	output gpl_pkg::result_t res
);
	import gpl_pkg::*;

	logic [WORD_W-1:0]   cfg_lo_q, cfg_hi_q, cfg_lo_d, cfg_hi_d;
	logic [NUM_PINS-1:0] od_q, od_d;
	logic [NUM_PINS-1:0] mask_q, mask_d;
	lock_step_t          step_q, step_d;
	logic                locked;
	logic [WORD_W-1:0]   keep_lo, keep_hi;
	logic                key, same;
	logic [WORD_W-1:0]   rdata;

	assign locked  = (step_q == ST_LOCKED);
	assign keep_lo = locked ? nibble_mask(mask_q[7:0]) : '0;
	assign keep_hi = locked ? nibble_mask(mask_q[15:8]) : '0;
	assign key     = acc.wdata[LOCK_KEY_BIT];
	assign same    = (acc.wdata[NUM_PINS-1:0] == mask_q);

	always_comb begin
		cfg_lo_d = cfg_lo_q;
		cfg_hi_d = cfg_hi_q;
		od_d     = od_q;
		mask_d   = mask_q;
		step_d   = step_q;
		rdata    = '0;
		if (acc.func == FUNC_WRITE) begin
			case (acc.sel)
				REG_CFG_LO: cfg_lo_d = (cfg_lo_q & keep_lo) | (acc.wdata & ~keep_lo);
				REG_CFG_HI: cfg_hi_d = (cfg_hi_q & keep_hi) | (acc.wdata & ~keep_hi);
				REG_OUT:    od_d = acc.wdata[NUM_PINS-1:0];
				REG_SET:    od_d = od_q | acc.wdata[NUM_PINS-1:0];
				REG_RESET:  od_d = od_q & ~acc.wdata[NUM_PINS-1:0];
				REG_LOCK: begin
					if (!locked) begin
						mask_d = acc.wdata[NUM_PINS-1:0];
						case (step_q)
							ST_W1: begin
								if (!key && same) step_d = ST_W2;
								else step_d = key ? ST_W1 : ST_IDLE;
							end
							ST_W2: begin
								if (key && same) step_d = ST_W3;
								else step_d = key ? ST_W1 : ST_IDLE;
							end
							default: step_d = key ? ST_W1 : ST_IDLE;
						endcase
					end
				end
				default: ;
			endcase
		end else begin
			case (acc.sel)
				REG_CFG_LO: rdata = cfg_lo_q;
				REG_CFG_HI: rdata = cfg_hi_q;
				REG_IN:     rdata = {{(WORD_W-NUM_PINS){1'b0}}, acc.pins};
				REG_OUT:    rdata = {{(WORD_W-NUM_PINS){1'b0}}, od_q};
				REG_LOCK: begin
					case (step_q)
						ST_W3:     step_d = ST_R1;
						ST_R1:     step_d = ST_LOCKED;
						ST_LOCKED: step_d = ST_LOCKED;
						default:   step_d = ST_IDLE;
					endcase
					rdata = {{(WORD_W-NUM_PINS-1){1'b0}}, (step_d == ST_LOCKED), mask_q};
				end
				default: rdata = '0;
			endcase
		end
	end

	assign res.rdata       = rdata;
	assign res.pins_driven = od_d;
	assign res.lock_active = (step_d == ST_LOCKED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_lo_q <= CFG_RESET;
			cfg_hi_q <= CFG_RESET;
			od_q     <= '0;
			mask_q   <= '0;
			step_q   <= ST_IDLE;
		end else if (en) begin
			cfg_lo_q <= cfg_lo_d;
			cfg_hi_q <= cfg_hi_d;
			od_q     <= od_d;
			mask_q   <= mask_d;
			step_q   <= step_d;
		end
	end

	`GPL_ASSERT_NEXT(a_lock_sticky, locked, step_q == ST_LOCKED, "lock released before reset")
	`GPL_ASSERT_NEXT(a_mask_frozen, locked, $stable(mask_q), "lock mask changed while locked")
	`GPL_ASSERT_NEXT(a_cfg_frozen, locked,
		(cfg_lo_q & $past(keep_lo)) == ($past(cfg_lo_q) & $past(keep_lo)),
		"locked configuration nibble changed")
	`GPL_ASSERT_NEXT(a_lock_entry, en && step_q != ST_R1 && !locked,
		step_q != ST_LOCKED, "lock completed without the key sequence")

endmodule
